/* rtl/core/qrs_pkg.sv */
// Shared types, constants and helpers of the quadratic root solver.
`timescale 1ns / 1ps

package qrs_pkg;

    // Default number format of the coefficient and root ports
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Quotient and root bits resolved per pipeline stage
    localparam int DIV_BITS_PER_STAGE  = 2;
    localparam int SQRT_BITS_PER_STAGE = 2;

    // Magnitude limit of every internal value
    localparam logic [63:0] IMAX = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef logic signed [63:0] fix_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    // Solution path chosen from the coefficients
    typedef enum logic [2:0] {
        PATH_NONE,
        PATH_LIN,
        PATH_CZERO,
        PATH_QSMALL,
        PATH_QLARGE
    } path_t;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_LINEAR  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Per-item context that travels beside the arithmetic
    typedef struct packed {
        path_t path;
        logic  cplx;
        logic  sat;
        fix_t  a;
        fix_t  b;
        fix_t  c;
        fix_t  h;
        fix_t  e;
        fix_t  lr;
        fix_t  sr;
        fix_t  si;
    } ctx_t;

    function automatic logic [63:0] mag(fix_t v);
        return v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
    endfunction

endpackage

/* rtl/core/qrs_unit.sv */
// Pipelined fixed-point multiply, divide or square root unit with context sideband.
`timescale 1ns / 1ps

module qrs_unit import qrs_pkg::*; #(
    parameter op_t OP        = OP_MUL,
    parameter int  FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic ce,
    input  logic in_valid,
    input  fix_t in_x,
    input  fix_t in_y,
    input  ctx_t in_ctx,
    output logic out_valid,
    output fix_t out_res,
    output logic out_sat,
    output ctx_t out_ctx
);

    logic        core_vld;
    logic [63:0] core_mag;
    logic        core_sat;
    logic        core_neg;
    ctx_t        core_ctx;

    logic        out_valid_reg;
    fix_t        out_res_reg;
    logic        out_sat_reg;
    ctx_t        out_ctx_reg;

    if (OP == OP_MUL) begin : g_mul
        logic [63:0]  mx_reg, my_reg;
        logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
        logic [127:0] prod_reg;
        logic [127:0] shifted;
        logic [2:0]   vld_reg;
        logic [2:0]   neg_reg;
        ctx_t         ctx_reg [3];

        // Advance valid bits
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= '0;
            end else if (ce) begin
                vld_reg <= {vld_reg[1:0], in_valid};
            end
        end

        // Capture magnitudes, form 32x32 partial products, then sum them
        always_ff @(posedge aclk) begin
            if (ce) begin
                mx_reg     <= mag(in_x);
                my_reg     <= mag(in_y);
                neg_reg[0] <= in_x[63] ^ in_y[63];
                ctx_reg[0] <= in_ctx;
                pp_ll_reg  <= 64'(mx_reg[31:0]) * 64'(my_reg[31:0]);
                pp_lh_reg  <= 64'(mx_reg[31:0]) * 64'(my_reg[63:32]);
                pp_hl_reg  <= 64'(mx_reg[63:32]) * 64'(my_reg[31:0]);
                pp_hh_reg  <= 64'(mx_reg[63:32]) * 64'(my_reg[63:32]);
                neg_reg[1] <= neg_reg[0];
                ctx_reg[1] <= ctx_reg[0];
                prod_reg   <= {64'd0, pp_ll_reg} + ({64'd0, pp_lh_reg} << 32)
                            + ({64'd0, pp_hl_reg} << 32) + {pp_hh_reg, 64'd0};
                neg_reg[2] <= neg_reg[1];
                ctx_reg[2] <= ctx_reg[1];
            end
        end

        // Drop fraction bits and clamp
        always_comb begin
            shifted  = prod_reg >> FRAC_BITS;
            core_sat = |shifted[127:62];
            core_mag = core_sat ? IMAX : {2'b00, shifted[61:0]};
            core_vld = vld_reg[2];
            core_neg = neg_reg[2];
            core_ctx = ctx_reg[2];
        end

    end else if (OP == OP_DIV) begin : g_div
        localparam int QW  = 64 + FRAC_BITS;
        localparam int NST = (QW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
        localparam int PW  = NST * DIV_BITS_PER_STAGE;

        logic [63:0]   rem_reg  [NST+1];
        logic [PW-1:0] nq_reg   [NST+1];
        logic [63:0]   den_reg  [NST+1];
        logic [NST:0]  neg_reg;
        logic [NST:0]  vld_reg;
        ctx_t          ctx_reg  [NST+1];
        logic [63:0]   rem_next [NST];
        logic [PW-1:0] nq_next  [NST];

        // Restoring division, a few quotient bits per stage
        always_comb begin
            logic [64:0]   trial;
            logic [63:0]   r;
            logic [PW-1:0] q;
            for (int j = 0; j < NST; j++) begin
                r = rem_reg[j];
                q = nq_reg[j];
                for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
                    trial = {r, q[PW-1]};
                    q     = {q[PW-2:0], 1'b0};
                    if (trial >= {1'b0, den_reg[j]}) begin
                        trial = trial - {1'b0, den_reg[j]};
                        q[0]  = 1'b1;
                    end
                    r = trial[63:0];
                end
                rem_next[j] = r;
                nq_next[j]  = q;
            end
        end

        // Advance valid bits
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= '0;
            end else if (ce) begin
                vld_reg <= {vld_reg[NST-1:0], in_valid};
            end
        end

        // Load the scaled dividend and shift through the stages
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[0] <= '0;
                nq_reg[0]  <= PW'(mag(in_x)) << FRAC_BITS;
                den_reg[0] <= mag(in_y);
                neg_reg[0] <= in_x[63] ^ in_y[63];
                ctx_reg[0] <= in_ctx;
                for (int j = 0; j < NST; j++) begin
                    rem_reg[j+1] <= rem_next[j];
                    nq_reg[j+1]  <= nq_next[j];
                    den_reg[j+1] <= den_reg[j];
                    neg_reg[j+1] <= neg_reg[j];
                    ctx_reg[j+1] <= ctx_reg[j];
                end
            end
        end

        // Zero divisor gives zero; clamp large quotients
        always_comb begin
            if (den_reg[NST] == 64'd0) begin
                core_sat = 1'b0;
                core_mag = '0;
            end else begin
                core_sat = |nq_reg[NST][PW-1:62];
                core_mag = core_sat ? IMAX : {2'b00, nq_reg[NST][61:0]};
            end
            core_vld = vld_reg[NST];
            core_neg = neg_reg[NST];
            core_ctx = ctx_reg[NST];
        end

    end else begin : g_sqrt
        localparam int RB  = (65 + FRAC_BITS) / 2;
        localparam int NST = (RB + SQRT_BITS_PER_STAGE - 1) / SQRT_BITS_PER_STAGE;
        localparam int SW  = NST * SQRT_BITS_PER_STAGE;
        localparam int RW  = SW + 2;

        logic [2*SW-1:0] rad_reg   [NST+1];
        logic [SW-1:0]   root_reg  [NST+1];
        logic [RW-1:0]   rem_reg   [NST+1];
        logic [NST:0]    vld_reg;
        ctx_t            ctx_reg   [NST+1];
        logic [2*SW-1:0] rad_next  [NST];
        logic [SW-1:0]   root_next [NST];
        logic [RW-1:0]   rem_next  [NST];

        // Digit-by-digit square root, a few root bits per stage
        always_comb begin
            logic [RW+1:0]   t;
            logic [RW+1:0]   trial;
            logic [RW-1:0]   r;
            logic [SW-1:0]   q;
            logic [2*SW-1:0] x;
            for (int j = 0; j < NST; j++) begin
                r = rem_reg[j];
                q = root_reg[j];
                x = rad_reg[j];
                for (int k = 0; k < SQRT_BITS_PER_STAGE; k++) begin
                    t     = {r, x[2*SW-1:2*SW-2]};
                    x     = {x[2*SW-3:0], 2'b00};
                    trial = {2'b00, q, 2'b01};
                    if (t >= trial) begin
                        t = t - trial;
                        q = {q[SW-2:0], 1'b1};
                    end else begin
                        q = {q[SW-2:0], 1'b0};
                    end
                    r = t[RW-1:0];
                end
                rem_next[j]  = r;
                root_next[j] = q;
                rad_next[j]  = x;
            end
        end

        // Advance valid bits
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= '0;
            end else if (ce) begin
                vld_reg <= {vld_reg[NST-1:0], in_valid};
            end
        end

        // Load the scaled radicand and shift through the stages
        always_ff @(posedge aclk) begin
            if (ce) begin
                rad_reg[0]  <= (2*SW)'(mag(in_x)) << FRAC_BITS;
                root_reg[0] <= '0;
                rem_reg[0]  <= '0;
                ctx_reg[0]  <= in_ctx;
                for (int j = 0; j < NST; j++) begin
                    rad_reg[j+1]  <= rad_next[j];
                    root_reg[j+1] <= root_next[j];
                    rem_reg[j+1]  <= rem_next[j];
                    ctx_reg[j+1]  <= ctx_reg[j];
                end
            end
        end

        always_comb begin
            core_sat = 1'b0;
            core_mag = 64'(root_reg[NST]);
            core_vld = vld_reg[NST];
            core_neg = 1'b0;
            core_ctx = ctx_reg[NST];
        end
    end

    // Hold the signed result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= core_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_res_reg <= core_neg ? fix_t'(64'd0 - core_mag) : fix_t'(core_mag);
            out_sat_reg <= core_sat;
            out_ctx_reg <= core_ctx;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_sat   = out_sat_reg;
    assign out_ctx   = out_ctx_reg;

endmodule

/* rtl/core/quadratic_root_solver.sv */
// Top level of the pipelined fixed-point quadratic root solver.
`timescale 1ns / 1ps

// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// Input channel s_*: one equation per transfer (coef_a, coef_b, coef_c).
// Result channel m_*: one transfer per equation, in order: both roots as
// real/imaginary pairs, the root kind and a saturation flag.
// Throughput: one equation per cycle while the output is not stalled. The path
//   from input transfer to m_valid runs through one divider, a multiplier, a
//   square root, a multiplier and three dividers, with
//   NDIV = ceil((64+FRAC_BITS)/2) stages per divider and
//   NSQ  = ceil(floor((65+FRAC_BITS)/2)/2) stages per square root.
// The whole pipeline advances while the output register is empty or being
// taken; when the receiver holds m_ready low with a result waiting, every
// stage holds and s_ready drops, so no item is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; no result is
// pending afterwards and the block is ready at once.

module quadratic_root_solver import qrs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_coef_a,
    input  logic signed [WORD_BITS-1:0] s_coef_b,
    input  logic signed [WORD_BITS-1:0] s_coef_c,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_large_root_real,
    output logic signed [WORD_BITS-1:0] m_large_root_imag,
    output logic signed [WORD_BITS-1:0] m_small_root_real,
    output logic signed [WORD_BITS-1:0] m_small_root_imag,
    output logic [1:0]                  m_root_kind,
    output logic                        m_saturated
);

    localparam fix_t WMAX = fix_t'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam fix_t WMIN = -WMAX - 64'sd1;
    localparam fix_t ONE  = fix_t'(64'd1 << FRAC_BITS);

    function automatic logic imax_over(fix_t v);
        return mag(v) > IMAX;
    endfunction

    function automatic fix_t imax_clamp(fix_t v);
        if (!imax_over(v)) begin
            return v;
        end
        return v[63] ? fix_t'(64'd0 - IMAX) : fix_t'(IMAX);
    endfunction

    function automatic logic word_over(fix_t v);
        return (v > WMAX) || (v < WMIN);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] word_clip(fix_t v);
        if (v > WMAX) begin
            return WMAX[WORD_BITS-1:0];
        end
        if (v < WMIN) begin
            return WMIN[WORD_BITS-1:0];
        end
        return v[WORD_BITS-1:0];
    endfunction

    logic ce;

    logic m_valid_reg;
    logic signed [WORD_BITS-1:0] lr_reg, li_reg, sr_reg, si_reg;
    kind_t kind_reg;
    logic  sat_reg;

    ctx_t ctx0, ctx1, ctx2, ctx3, ctx4, ctx5, ctx6, ctxf;
    fix_t x1, y1, x1b, y1b, x2, y2, x3, x3b, x4, y4, x5, y5, x5b, y5b, x6, y6, x7, y7;
    fix_t sum2, d4, t4;
    logic quad2, quad4, quad5, live6, livef;
    logic signed [WORD_BITS-1:0] lr_next, li_next, sr_next, si_next;
    kind_t kind_next;
    logic  sat_next;

    logic u1_vld, u2_vld, u3_vld, u4_vld, u5_vld, u6_vld, u7_vld;
    fix_t u1_res, u1b_res, u2_res, u3_res, u3b_res, u4_res, u5_res, u5b_res, u6_res, u7_res;
    logic u1_sat, u1b_sat, u2_sat, u4_sat, u5_sat, u5b_sat, u6_sat, u7_sat;
    ctx_t u1_ctx, u2_ctx, u3_ctx, u4_ctx, u5_ctx, u6_ctx, u7_ctx;

    // Advance the whole pipeline unless a result waits at a stalled receiver
    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    // Classify the equation and pick the first division
    always_comb begin
        ctx0   = '0;
        ctx0.a = fix_t'(s_coef_a);
        ctx0.b = fix_t'(s_coef_b);
        ctx0.c = fix_t'(s_coef_c);
        ctx0.h = (ctx0.b >>> 1) + fix_t'({63'd0, ctx0.b[63] & ctx0.b[0]});
        if (ctx0.a == '0) begin
            ctx0.path = (ctx0.b != '0) ? PATH_LIN : PATH_NONE;
        end else if (ctx0.c == '0) begin
            ctx0.path = PATH_CZERO;
        end else if (mag(ctx0.h) < mag(ctx0.c)) begin
            ctx0.path = PATH_QSMALL;
        end else begin
            ctx0.path = PATH_QLARGE;
        end
        case (ctx0.path)
            PATH_LIN: begin
                x1 = -ctx0.c;
                y1 = ctx0.b;
            end
            PATH_CZERO: begin
                x1 = -ctx0.b;
                y1 = ctx0.a;
            end
            PATH_QSMALL: begin
                x1 = ctx0.h;
                y1 = fix_t'(mag(ctx0.c));
            end
            PATH_QLARGE: begin
                x1 = ctx0.a;
                y1 = ctx0.h;
            end
            default: begin
                x1 = '0;
                y1 = '0;
            end
        endcase
        x1b = ctx0.c;
        y1b = ctx0.h;
    end

    qrs_unit #(.OP(OP_DIV), .FRAC_BITS(FRAC_BITS)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_valid && ce), .in_x(x1), .in_y(y1), .in_ctx(ctx0),
        .out_valid(u1_vld), .out_res(u1_res), .out_sat(u1_sat), .out_ctx(u1_ctx)
    );

    qrs_unit #(.OP(OP_DIV), .FRAC_BITS(FRAC_BITS)) u_div1b (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_valid && ce), .in_x(x1b), .in_y(y1b), .in_ctx('0),
        .out_valid(), .out_res(u1b_res), .out_sat(u1b_sat), .out_ctx()
    );

    // Keep the linear and c-zero roots; form the product for the scaled term
    always_comb begin
        ctx1 = u1_ctx;
        x2   = u1_res;
        y2   = u1b_res;
        case (ctx1.path)
            PATH_LIN: begin
                ctx1.sr  = u1_res;
                ctx1.sat = u1_sat;
            end
            PATH_CZERO: begin
                ctx1.lr  = u1_res;
                ctx1.sat = u1_sat;
            end
            PATH_QSMALL: begin
                ctx1.sat = u1_sat;
                x2       = ctx1.h;
                y2       = u1_res;
            end
            PATH_QLARGE: begin
                ctx1.sat = u1_sat || u1b_sat;
            end
            default: begin
                ctx1.sat = 1'b0;
            end
        endcase
    end

    qrs_unit #(.OP(OP_MUL), .FRAC_BITS(FRAC_BITS)) u_mul2 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u1_vld), .in_x(x2), .in_y(y2), .in_ctx(ctx1),
        .out_valid(u2_vld), .out_res(u2_res), .out_sat(u2_sat), .out_ctx(u2_ctx)
    );

    // Form the scaled discriminant e
    always_comb begin
        ctx2  = u2_ctx;
        quad2 = (ctx2.path == PATH_QSMALL) || (ctx2.path == PATH_QLARGE);
        if (ctx2.path == PATH_QSMALL) begin
            sum2 = (ctx2.c[63] ? ctx2.a : -ctx2.a) + u2_res;
        end else begin
            sum2 = ONE - u2_res;
        end
        if (quad2) begin
            ctx2.e   = imax_clamp(sum2);
            ctx2.sat = ctx2.sat || u2_sat || imax_over(sum2);
        end
        x3  = ctx2.e;
        x3b = ctx2.c;
    end

    qrs_unit #(.OP(OP_SQRT), .FRAC_BITS(FRAC_BITS)) u_sqrt3 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u2_vld), .in_x(x3), .in_y('0), .in_ctx(ctx2),
        .out_valid(u3_vld), .out_res(u3_res), .out_sat(), .out_ctx(u3_ctx)
    );

    qrs_unit #(.OP(OP_SQRT), .FRAC_BITS(FRAC_BITS)) u_sqrt3b (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u2_vld), .in_x(x3b), .in_y('0), .in_ctx('0),
        .out_valid(), .out_res(u3b_res), .out_sat(), .out_ctx()
    );

    // Scale the root of e back
    always_comb begin
        ctx3 = u3_ctx;
        x4   = u3_res;
        y4   = (ctx3.path == PATH_QSMALL) ? u3b_res : fix_t'(mag(ctx3.h));
    end

    qrs_unit #(.OP(OP_MUL), .FRAC_BITS(FRAC_BITS)) u_mul4 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u3_vld), .in_x(x4), .in_y(y4), .in_ctx(ctx3),
        .out_valid(u4_vld), .out_res(u4_res), .out_sat(u4_sat), .out_ctx(u4_ctx)
    );

    // Build the large-root numerator, or split off the complex pair
    always_comb begin
        ctx4  = u4_ctx;
        quad4 = (ctx4.path == PATH_QSMALL) || (ctx4.path == PATH_QLARGE);
        d4    = ctx4.h[63] ? u4_res : -u4_res;
        t4    = -ctx4.h + d4;
        if (quad4) begin
            ctx4.cplx = ctx4.e[63];
            ctx4.sat  = ctx4.sat || u4_sat || (!ctx4.e[63] && imax_over(t4));
        end
        x5  = ctx4.cplx ? ctx4.h : imax_clamp(t4);
        y5  = ctx4.a;
        x5b = u4_res;
        y5b = ctx4.a;
    end

    qrs_unit #(.OP(OP_DIV), .FRAC_BITS(FRAC_BITS)) u_div5 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u4_vld), .in_x(x5), .in_y(y5), .in_ctx(ctx4),
        .out_valid(u5_vld), .out_res(u5_res), .out_sat(u5_sat), .out_ctx(u5_ctx)
    );

    qrs_unit #(.OP(OP_DIV), .FRAC_BITS(FRAC_BITS)) u_div5b (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u4_vld), .in_x(x5b), .in_y(y5b), .in_ctx('0),
        .out_valid(), .out_res(u5b_res), .out_sat(u5b_sat), .out_ctx()
    );

    // Take the large root, or both halves of the complex pair
    always_comb begin
        ctx5  = u5_ctx;
        quad5 = (ctx5.path == PATH_QSMALL) || (ctx5.path == PATH_QLARGE);
        if (quad5) begin
            if (ctx5.cplx) begin
                ctx5.lr  = -u5_res;
                ctx5.sr  = -u5_res;
                ctx5.si  = fix_t'(mag(u5b_res));
                ctx5.sat = ctx5.sat || u5_sat || u5b_sat;
            end else begin
                ctx5.lr  = u5_res;
                ctx5.sat = ctx5.sat || u5_sat;
            end
        end
        x6 = ctx5.c;
        y6 = ctx5.lr;
    end

    qrs_unit #(.OP(OP_DIV), .FRAC_BITS(FRAC_BITS)) u_div6 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u5_vld), .in_x(x6), .in_y(y6), .in_ctx(ctx5),
        .out_valid(u6_vld), .out_res(u6_res), .out_sat(u6_sat), .out_ctx(u6_ctx)
    );

    // First half of the small root: c over the large root
    always_comb begin
        ctx6  = u6_ctx;
        live6 = ((ctx6.path == PATH_QSMALL) || (ctx6.path == PATH_QLARGE))
                && !ctx6.cplx && (ctx6.lr != '0);
        if (live6) begin
            ctx6.sat = ctx6.sat || u6_sat;
        end
        x7 = u6_res;
        y7 = ctx6.a;
    end

    qrs_unit #(.OP(OP_DIV), .FRAC_BITS(FRAC_BITS)) u_div7 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(u6_vld), .in_x(x7), .in_y(y7), .in_ctx(ctx6),
        .out_valid(u7_vld), .out_res(u7_res), .out_sat(u7_sat), .out_ctx(u7_ctx)
    );

    // Finish the small root, clip every field to the port width
    always_comb begin
        ctxf  = u7_ctx;
        livef = ((ctxf.path == PATH_QSMALL) || (ctxf.path == PATH_QLARGE))
                && !ctxf.cplx && (ctxf.lr != '0);
        if (livef) begin
            ctxf.sr  = u7_res;
            ctxf.sat = ctxf.sat || u7_sat;
        end
        lr_next  = word_clip(ctxf.lr);
        li_next  = word_clip(-ctxf.si);
        sr_next  = word_clip(ctxf.sr);
        si_next  = word_clip(ctxf.si);
        sat_next = ctxf.sat || word_over(ctxf.lr) || word_over(-ctxf.si)
                   || word_over(ctxf.sr) || word_over(ctxf.si);
        case (ctxf.path)
            PATH_LIN:    kind_next = KIND_LINEAR;
            PATH_NONE:   kind_next = KIND_NONE;
            PATH_QSMALL,
            PATH_QLARGE: kind_next = ctxf.cplx ? KIND_COMPLEX : KIND_REAL;
            default:     kind_next = KIND_REAL;
        endcase
    end

    // Hold the result until the receiver takes the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= u7_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lr_reg   <= lr_next;
            li_reg   <= li_next;
            sr_reg   <= sr_next;
            si_reg   <= si_next;
            kind_reg <= kind_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_large_root_real = lr_reg;
    assign m_large_root_imag = li_reg;
    assign m_small_root_real = sr_reg;
    assign m_small_root_imag = si_reg;
    assign m_root_kind       = kind_reg;
    assign m_saturated       = sat_reg;

endmodule

/* tb/sv/quadratic_root_solver_tb.sv */
// Self-checking testbench of the quadratic root solver: directed and random equations.
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int FB          = 16;
    localparam int NUM_RANDOM  = 1800;
    localparam int DRAIN_WAIT  = 260;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [63:0] MAG_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] lr;
        logic signed [31:0] li;
        logic signed [31:0] sr;
        logic signed [31:0] si;
        kind_t              kind;
        logic               sat;
    } roots_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               typed;
        roots_t             want;
    } eq_row_t;

    localparam roots_t NO_ROOTS = '{0, 0, 0, 0, KIND_REAL, 1'b0};

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_coef_a;
    logic signed [31:0] s_coef_b;
    logic signed [31:0] s_coef_c;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_large_root_real;
    logic signed [31:0] m_large_root_imag;
    logic signed [31:0] m_small_root_real;
    logic signed [31:0] m_small_root_imag;
    logic [1:0]         m_root_kind;
    logic               m_saturated;

    roots_t pending_roots[$];
    int     error_count;
    int     cycle_count;
    int     stall_left;
    logic   clamp_seen;

    quadratic_root_solver dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_coef_a          (s_coef_a),
        .s_coef_b          (s_coef_b),
        .s_coef_c          (s_coef_c),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_large_root_real (m_large_root_real),
        .m_large_root_imag (m_large_root_imag),
        .m_small_root_real (m_small_root_real),
        .m_small_root_imag (m_small_root_imag),
        .m_root_kind       (m_root_kind),
        .m_saturated       (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Fixed-point arithmetic of the root solver, 64-bit intermediates
    function automatic logic [63:0] abs64(fix_t v);
        return v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
    endfunction

    function automatic fix_t apply_sign(logic neg, logic [63:0] m);
        if (m > MAG_LIMIT) begin
            clamp_seen = 1'b1;
            m = MAG_LIMIT;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic fix_t clamp64(fix_t v);
        return apply_sign(v < 0, abs64(v));
    endfunction

    function automatic fix_t fix_mul(fix_t x, fix_t y);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, abs64(x)} * {64'd0, abs64(y)};
        if (p[127:64+FB] != 0) begin
            clamp_seen = 1'b1;
            m = MAG_LIMIT;
        end else begin
            m = p[63+FB:FB];
        end
        return apply_sign((x < 0) != (y < 0), m);
    endfunction

    function automatic fix_t fix_div(fix_t n, fix_t d);
        logic [63:0] un, ud, q;
        logic [79:0] wide_q;
        un = abs64(n);
        ud = abs64(d);
        if (ud == 0) return 0;
        q = un / ud;
        if (q > (MAG_LIMIT >> FB)) begin
            clamp_seen = 1'b1;
            q = MAG_LIMIT;
        end else begin
            wide_q = {un, 16'd0} / {16'd0, ud};
            q = wide_q[63:0];
        end
        return apply_sign((n < 0) != (d < 0), q);
    endfunction

    function automatic fix_t fix_sqrt(fix_t x);
        logic [127:0] target, trial, r;
        target = {48'd0, abs64(x), 16'd0};
        r = 0;
        for (int k = 47; k >= 0; k--) begin
            trial = r | (128'd1 << k);
            if (trial * trial <= target) r = trial;
        end
        return $signed(r[63:0]);
    endfunction

    function automatic logic signed [31:0] to_word(fix_t v);
        if (v > 64'sd2147483647) begin
            clamp_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            clamp_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Predict both roots of a*x^2 + b*x + c
    function automatic roots_t solve_roots(logic signed [31:0] ca, logic signed [31:0] cb,
                                           logic signed [31:0] cc);
        fix_t   a, b, c, h, e, d, lr, li, sr, si;
        roots_t r;
        a = ca; b = cb; c = cc;
        lr = 0; li = 0; sr = 0; si = 0;
        r.kind = KIND_REAL;
        clamp_seen = 1'b0;
        if (a == 0) begin
            if (b != 0) begin
                sr = fix_div(-c, b);
                r.kind = KIND_LINEAR;
            end else begin
                r.kind = KIND_NONE;
            end
        end else if (c == 0) begin
            lr = fix_div(-b, a);
        end else begin
            h = b / 64'sd2;
            // pick the branch that keeps the discriminant in range
            if (abs64(h) < abs64(c)) begin
                e = (c >= 0) ? a : -a;
                e = clamp64(-e + fix_mul(h, fix_div(h, $signed(abs64(c)))));
                d = fix_mul(fix_sqrt(e), fix_sqrt(c));
            end else begin
                e = clamp64((64'sd1 <<< FB) - fix_mul(fix_div(a, h), fix_div(c, h)));
                d = fix_mul(fix_sqrt(e), $signed(abs64(h)));
            end
            if (e >= 0) begin
                if (h >= 0) d = -d;
                lr = fix_div(clamp64(-h + d), a);
                sr = (lr != 0) ? fix_div(fix_div(c, lr), a) : 0;
            end else begin
                lr = -fix_div(h, a);
                sr = lr;
                si = $signed(abs64(fix_div(d, a)));
                li = -si;
                r.kind = KIND_COMPLEX;
            end
        end
        r.lr = to_word(lr);
        r.li = to_word(li);
        r.sr = to_word(sr);
        r.si = to_word(si);
        r.sat = clamp_seen;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    // Random coefficient: zeros, extremes, plus or minus one, full range and small magnitudes
    function automatic logic signed [31:0] pick_coef();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 0;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0001_0000;
                    default: return -32'sh0001_0000;
                endcase
            end
            2, 3, 4: return $urandom;
            default: begin
                if ($urandom_range(0, 1)) return $urandom_range(1, 1 << 21);
                return -$signed($urandom_range(1, 1 << 21));
            end
        endcase
    endfunction

    // After an optional random gap, hold one equation on the input until its transfer, then queue the roots
    task automatic send_equation(logic signed [31:0] a, logic signed [31:0] b,
                                 logic signed [31:0] c, logic typed, roots_t want,
                                 bit gappy);
        int gap;
        gap = 0;
        if (gappy) begin
            case ($urandom_range(0, 19))
                0: gap = $urandom_range(10, 40);
                1, 2, 3: gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_roots.push_back(typed ? want : solve_roots(a, b, c));
    endtask

    // Check each result transfer and drive receiver stalls
    always @(posedge aclk) begin : result_check
        roots_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_roots.size() == 0) begin
                    $display("[%0t] result transfer with nothing outstanding", $time);
                    error_count++;
                end else begin
                    want = pending_roots.pop_front();
                    if (m_large_root_real !== want.lr)
                        report_mismatch("large_root_real", m_large_root_real, want.lr);
                    if (m_large_root_imag !== want.li)
                        report_mismatch("large_root_imag", m_large_root_imag, want.li);
                    if (m_small_root_real !== want.sr)
                        report_mismatch("small_root_real", m_small_root_real, want.sr);
                    if (m_small_root_imag !== want.si)
                        report_mismatch("small_root_imag", m_small_root_imag, want.si);
                    if (m_root_kind !== want.kind)
                        report_mismatch("root_kind", m_root_kind, want.kind);
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", m_saturated, want.sat);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                case ($urandom_range(0, 29))
                    0: begin
                        stall_left <= $urandom_range(10, 40);
                        m_ready    <= 1'b0;
                    end
                    1, 2, 3, 4: begin
                        stall_left <= $urandom_range(0, 2);
                        m_ready    <= 1'b0;
                    end
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // End the run as failed once the cycle count reaches CYCLE_LIMIT
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        eq_row_t directed[] = '{
            // no equation: a = 0, b = 0
            '{32'sh0, 32'sh0, 32'sh0005_0000, 1'b1, '{0, 0, 0, 0, KIND_NONE, 1'b0}},
            // linear x + 3 = 0
            '{32'sh0, 32'sh0001_0000, 32'sh0003_0000, 1'b1,
              '{0, 0, -32'sh0003_0000, 0, KIND_LINEAR, 1'b0}},
            // c = 0: x^2 - 2x
            '{32'sh0001_0000, -32'sh0002_0000, 32'sh0, 1'b1,
              '{32'sh0002_0000, 0, 0, 0, KIND_REAL, 1'b0}},
            // c = 0 with the most negative b: root clamps
            '{32'sh0001_0000, 32'sh8000_0000, 32'sh0, 1'b1,
              '{32'sh7FFF_FFFF, 0, 0, 0, KIND_REAL, 1'b1}},
            // x^2 + 1: pure imaginary pair
            '{32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b1,
              '{0, -32'sh0001_0000, 0, 32'sh0001_0000, KIND_COMPLEX, 1'b0}},
            '{32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000, 1'b0, NO_ROOTS},
            '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0, NO_ROOTS},
            '{-32'sh0001_0000, 32'sh0, 32'sh0004_0000, 1'b0, NO_ROOTS},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, NO_ROOTS},
            '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, NO_ROOTS},
            '{32'sh0000_0001, 32'sh0000_0001, 32'sh8000_0000, 1'b0, NO_ROOTS},
            '{32'sh0000_0001, 32'sh0, 32'sh7FFF_FFFF, 1'b0, NO_ROOTS},
            '{32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0000_0001, 1'b0, NO_ROOTS},
            '{32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 1'b0, NO_ROOTS},
            '{32'sh0001_0000, 32'sh0000_0001, -32'sh0000_0001, 1'b0, NO_ROOTS},
            '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, NO_ROOTS},
            '{32'sh0, 32'sh0000_0001, 32'sh8000_0000, 1'b0, NO_ROOTS},
            '{32'sh8000_0000, 32'sh0, 32'sh0, 1'b0, NO_ROOTS},
            '{-32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, NO_ROOTS}
        };
        bit gappy;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_coef_a    = '0;
        s_coef_b    = '0;
        s_coef_c    = '0;
        m_ready     = 1'b0;
        stall_left  = 0;
        error_count = 0;
        cycle_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        foreach (directed[i])
            send_equation(directed[i].a, directed[i].b, directed[i].c,
                          directed[i].typed, directed[i].want, 1'b1);

        // random equations in stretches of 150, each randomly bursty or gappy, with a drain halfway
        gappy = 1'b1;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 150 == 0) gappy = $urandom_range(0, 2) != 0;
            if (n == NUM_RANDOM / 2) begin
                s_valid <= 1'b0;
                while (pending_roots.size() != 0) @(posedge aclk);
            end
            send_equation(pick_coef(), pick_coef(), pick_coef(), 1'b0, NO_ROOTS, gappy);
        end
        s_valid <= 1'b0;

        // drain the pipeline
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
